FILE: rtl/itpd_pkg.sv
// Shared constants and types for the integer to padded decimal formatter.
package itpd_pkg;

   localparam int VALUE_W    = 64;
   localparam int NUM_DIGITS = 19;
   localparam int BCD_W      = 4;
   localparam int POS_W      = 5;
   localparam int BIT_CNT_W  = 6;
   localparam int MIN_W      = 5;
   localparam int CHAR_W     = 8;

   localparam logic [MIN_W-1:0]     MAX_PAD_DIGITS = MIN_W'(18);
   localparam logic [BIT_CNT_W-1:0] BIT_CNT_LAST   = BIT_CNT_W'(VALUE_W - 1);
   localparam logic [POS_W-1:0]     POS_TOP        = POS_W'(NUM_DIGITS - 1);
   localparam logic [BCD_W-1:0]     DABBLE_LIMIT   = BCD_W'(5);
   localparam logic [BCD_W-1:0]     DABBLE_ADD     = BCD_W'(3);
   localparam logic [CHAR_W-1:0]    CHAR_ZERO      = 8'h30;
   localparam logic [CHAR_W-1:0]    CHAR_MINUS     = 8'h2D;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SIGN,
      ST_DIGITS
   } state_type;

   typedef struct packed {
      logic clear;
      logic dabble;
      logic shift;
   } cell_ctl_type;

endpackage

FILE: rtl/itpd_digit_cell.sv
// One BCD digit cell of the shift-and-add-3 conversion chain.
module itpd_digit_cell (
   input  logic                        clock,
   input  itpd_pkg::cell_ctl_type      ctl,
   input  logic                        bit_in,
   input  logic [itpd_pkg::BCD_W-1:0]  digit_in,
   output logic                        bit_out,
   output logic [itpd_pkg::BCD_W-1:0]  digit_out
);

   logic [itpd_pkg::BCD_W-1:0] digit_ff;
   logic [itpd_pkg::BCD_W-1:0] adj;

   always_comb begin
      if (digit_ff >= itpd_pkg::DABBLE_LIMIT) begin
         adj = digit_ff + itpd_pkg::DABBLE_ADD;
      end else begin
         adj = digit_ff;
      end
   end

   assign bit_out   = adj[itpd_pkg::BCD_W-1];
   assign digit_out = digit_ff;

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         digit_ff <= '0;
      end else if (ctl.dabble) begin
         digit_ff <= {adj[itpd_pkg::BCD_W-2:0], bit_in};
      end else if (ctl.shift) begin
         digit_ff <= digit_in;
      end
   end

endmodule

FILE: rtl/integer_to_padded_decimal.sv
// Signed 64-bit integer to zero-padded decimal ASCII text, one character per beat.
// Each accepted value is converted by shifting its magnitude, one bit a cycle,
// through a chain of 19 BCD digit cells; the chain is then unloaded most significant
// digit first, one digit position per cycle while the output is free to take a
// character, with an extra beat for a leading '-'. Leading zero positions above the
// padding width are dropped without a beat. csr_wr_data sets the minimum digit count
// (values above 18 act as 18); the sign is not counted. The last character carries
// rsp_last.
module integer_to_padded_decimal (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [itpd_pkg::VALUE_W-1:0] req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [itpd_pkg::CHAR_W-1:0]         rsp_character,
   output logic                                rsp_last,
   input  logic                                csr_wr_en,
   input  logic [itpd_pkg::MIN_W-1:0]          csr_wr_data
);

   itpd_pkg::state_type state_ff, state_in;
   logic [itpd_pkg::VALUE_W-1:0]   mag_ff, mag_in;
   logic                           neg_ff, neg_in;
   logic [itpd_pkg::BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [itpd_pkg::POS_W-1:0]     pos_ff, pos_in;
   logic                           seen_ff, seen_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [itpd_pkg::CHAR_W-1:0]    rsp_char_ff, rsp_char_in;
   logic                           rsp_last_ff, rsp_last_in;
   logic [itpd_pkg::MIN_W-1:0]     min_digits_ff;

   logic [itpd_pkg::MIN_W-1:0]     pad;
   logic                           out_free;
   logic                           emit;
   logic [itpd_pkg::BCD_W-1:0]     top_digit;
   itpd_pkg::cell_ctl_type         ctl;

   logic                           cell_bit   [itpd_pkg::NUM_DIGITS];
   logic [itpd_pkg::BCD_W-1:0]     cell_digit [itpd_pkg::NUM_DIGITS];

   for (genvar i = 0; i < itpd_pkg::NUM_DIGITS; i++) begin : g_cell
      if (i == 0) begin : g_first
         itpd_digit_cell u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .bit_in    (mag_ff[itpd_pkg::VALUE_W-1]),
            .digit_in  ('0),
            .bit_out   (cell_bit[i]),
            .digit_out (cell_digit[i])
         );
      end else begin : g_rest
         itpd_digit_cell u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .bit_in    (cell_bit[i-1]),
            .digit_in  (cell_digit[i-1]),
            .bit_out   (cell_bit[i]),
            .digit_out (cell_digit[i])
         );
      end
   end

   assign top_digit = cell_digit[itpd_pkg::NUM_DIGITS-1];
   assign pad = (min_digits_ff > itpd_pkg::MAX_PAD_DIGITS) ? itpd_pkg::MAX_PAD_DIGITS
                                                          : min_digits_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit = seen_ff || (top_digit != '0) || ({1'b0, pos_ff} < {1'b0, pad})
                 || (pos_ff == '0);

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      bit_cnt_in   = bit_cnt_ff;
      pos_in       = pos_ff;
      seen_in      = seen_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      ctl          = '0;
      req_ready    = 1'b0;
      case (state_ff)
         itpd_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               neg_in     = req_value[itpd_pkg::VALUE_W-1];
               mag_in     = req_value[itpd_pkg::VALUE_W-1] ? ('0 - req_value) : req_value;
               bit_cnt_in = '0;
               ctl.clear  = 1'b1;
               state_in   = itpd_pkg::ST_CONVERT;
            end
         end
         itpd_pkg::ST_CONVERT: begin
            ctl.dabble = 1'b1;
            mag_in     = {mag_ff[itpd_pkg::VALUE_W-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == itpd_pkg::BIT_CNT_LAST) begin
               pos_in   = itpd_pkg::POS_TOP;
               seen_in  = 1'b0;
               state_in = neg_ff ? itpd_pkg::ST_SIGN : itpd_pkg::ST_DIGITS;
            end
         end
         itpd_pkg::ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = itpd_pkg::CHAR_MINUS;
               rsp_last_in  = 1'b0;
               state_in     = itpd_pkg::ST_DIGITS;
            end
         end
         itpd_pkg::ST_DIGITS: begin
            if (out_free) begin
               if (emit) begin
                  rsp_valid_in = 1'b1;
                  rsp_char_in  = itpd_pkg::CHAR_ZERO + {4'b0, top_digit};
                  rsp_last_in  = (pos_ff == '0);
                  seen_in      = 1'b1;
               end
               ctl.shift = 1'b1;
               pos_in    = pos_ff - 1'b1;
               if (pos_ff == '0) begin
                  state_in = itpd_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = itpd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= itpd_pkg::ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         min_digits_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            min_digits_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      bit_cnt_ff  <= bit_cnt_in;
      pos_ff      <= pos_in;
      seen_ff     <= seen_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

endmodule
